@@ sv/y2r_pkg.sv @@
package y2r_pkg;

    // Fixed-point coefficients in thousandths.
    localparam int COEF_W = 12;
    localparam logic signed [COEF_W-1:0] COEF_Y  = 12'sd1164;
    localparam logic signed [COEF_W-1:0] COEF_RV = 12'sd1596;
    localparam logic signed [COEF_W-1:0] COEF_GV = -12'sd813;
    localparam logic signed [COEF_W-1:0] COEF_BU = 12'sd2018;
    localparam logic signed [COEF_W-1:0] COEF_GU = -12'sd391;

    localparam logic signed [8:0] LUMA_OFFSET = 9'sd16;
    localparam logic [7:0] PIXEL_MAX = 8'd255;

    // Reciprocal of 1000 scaled by 2**RECIP_SHIFT, rounded up. It is exact for
    // every product magnitude up to 400000, which covers the largest luma
    // product of 1164 * 239.
    localparam int RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    localparam int PROD_W = 20;
    localparam int TERM_W = 10;
    localparam int SUM_W  = 12;

    typedef logic signed [PROD_W-1:0] prod_val_t;
    typedef logic signed [TERM_W-1:0] term_val_t;
    typedef logic signed [SUM_W-1:0]  sum_val_t;

    // One macropixel as it arrives.
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } ycc_t;

    // Raw coefficient products, still in thousandths.
    typedef struct packed {
        prod_val_t y0;
        prod_val_t y1;
        prod_val_t rv;
        prod_val_t gv;
        prod_val_t gu;
        prod_val_t bu;
    } prod_t;

    // Colour terms after truncation toward zero.
    typedef struct packed {
        term_val_t y0;
        term_val_t y1;
        term_val_t rv;
        term_val_t gv;
        term_val_t gu;
        term_val_t bu;
    } term_t;

    // Two clamped RGB888 pixels.
    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } rgb_pair_t;

    // Coefficient times an offset component; the result fits in PROD_W bits.
    function automatic prod_val_t mult_term(input logic signed [COEF_W-1:0] coef,
                                            input logic signed [8:0] off);
        logic signed [COEF_W+8:0] full;
        full = coef * off;
        return full[PROD_W-1:0];
    endfunction

    // Signed division by 1000, truncated toward zero, by reciprocal multiply.
    function automatic term_val_t div_term(input prod_val_t p);
        logic signed [PROD_W-1:0] neg;
        logic [PROD_W-2:0] mag;
        logic [PROD_W-2+19:0] scaled;
        logic [8:0] quo;
        logic signed [TERM_W-1:0] pos;
        neg = -p;
        mag = p[PROD_W-1] ? neg[PROD_W-2:0] : p[PROD_W-2:0];
        scaled = mag * RECIP_1000;
        quo = scaled[RECIP_SHIFT+8:RECIP_SHIFT];
        pos = $signed({1'b0, quo});
        return p[PROD_W-1] ? -pos : pos;
    endfunction

    // Sign-extend a term to the width of the sums.
    function automatic sum_val_t ext_term(input term_val_t t);
        return {{(SUM_W-TERM_W){t[TERM_W-1]}}, t};
    endfunction

endpackage

@@ sv/yuyv_to_rgb888_converter.sv @@
// Converts one YUYV macropixel per transfer into two BT.601 RGB888 pixels that
// share the macropixel's U and V. The datapath is three register stages
// (coefficient products, divide by 1000 through a reciprocal multiply, then
// sum and clamp), so a result passes through the product, term and output
// registers in that order before it is offered on the output. One macropixel
// is taken every clock while the output side is ready. Each stage has its
// own valid bit and holds its content under backpressure, so empty stages
// keep filling while a finished result waits.
module yuyv_to_rgb888_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // luma_first, chroma_blue, luma_second, chroma_red (lowest bits first)
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_first, green_first, blue_first, red_second, green_second,
    // blue_second (lowest bits first)
    output logic [47:0] m_axis_tdata
);

    y2r_pkg::ycc_t      in_pix;
    y2r_pkg::prod_t     prod_data;
    y2r_pkg::term_t     term_data;
    y2r_pkg::rgb_pair_t rgb_data;
    logic prod_valid;
    logic prod_ready;
    logic term_valid;
    logic term_ready;

    // Unpack the incoming macropixel.
    assign in_pix.luma_first  = s_axis_tdata[7:0];
    assign in_pix.chroma_blue = s_axis_tdata[15:8];
    assign in_pix.luma_second = s_axis_tdata[23:16];
    assign in_pix.chroma_red  = s_axis_tdata[31:24];

    y2r_term_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_pix),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    y2r_term_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term_data)
    );

    y2r_pixel_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (rgb_data)
    );

    // Pack the two pixels, first pixel in the lowest bytes.
    assign m_axis_tdata = {rgb_data.blue_second, rgb_data.green_second,
                           rgb_data.red_second, rgb_data.blue_first,
                           rgb_data.green_first, rgb_data.red_first};

endmodule

@@ sv/y2r_term_mult.sv @@
module y2r_term_mult (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  y2r_pkg::ycc_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output y2r_pkg::prod_t  out_data
);

    logic signed [8:0] off_y0;
    logic signed [8:0] off_y1;
    logic signed [8:0] off_u;
    logic signed [8:0] off_v;
    y2r_pkg::prod_t prod_next;
    y2r_pkg::prod_t prod_reg;
    logic valid_reg;

    // Remove the luma and chroma offsets. Flipping the top bit subtracts 128.
    assign off_y0 = $signed({1'b0, in_data.luma_first}) - y2r_pkg::LUMA_OFFSET;
    assign off_y1 = $signed({1'b0, in_data.luma_second}) - y2r_pkg::LUMA_OFFSET;
    assign off_u  = $signed({~in_data.chroma_blue[7], ~in_data.chroma_blue[7],
                             in_data.chroma_blue[6:0]});
    assign off_v  = $signed({~in_data.chroma_red[7], ~in_data.chroma_red[7],
                             in_data.chroma_red[6:0]});

    // Six independent coefficient products.
    always_comb
    begin
        prod_next.y0 = y2r_pkg::mult_term(y2r_pkg::COEF_Y, off_y0);
        prod_next.y1 = y2r_pkg::mult_term(y2r_pkg::COEF_Y, off_y1);
        prod_next.rv = y2r_pkg::mult_term(y2r_pkg::COEF_RV, off_v);
        prod_next.gv = y2r_pkg::mult_term(y2r_pkg::COEF_GV, off_v);
        prod_next.gu = y2r_pkg::mult_term(y2r_pkg::COEF_GU, off_u);
        prod_next.bu = y2r_pkg::mult_term(y2r_pkg::COEF_BU, off_u);
    end

    // The stage takes a new transfer when empty or when its content moves on.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = prod_reg;

endmodule

@@ sv/y2r_term_div.sv @@
module y2r_term_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  y2r_pkg::prod_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output y2r_pkg::term_t  out_data
);

    y2r_pkg::term_t term_next;
    y2r_pkg::term_t term_reg;
    logic valid_reg;

    // Scale each product back from thousandths, truncating toward zero.
    always_comb
    begin
        term_next.y0 = y2r_pkg::div_term(in_data.y0);
        term_next.y1 = y2r_pkg::div_term(in_data.y1);
        term_next.rv = y2r_pkg::div_term(in_data.rv);
        term_next.gv = y2r_pkg::div_term(in_data.gv);
        term_next.gu = y2r_pkg::div_term(in_data.gu);
        term_next.bu = y2r_pkg::div_term(in_data.bu);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            term_reg <= term_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = term_reg;

endmodule

@@ sv/y2r_pixel_sum.sv @@
module y2r_pixel_sum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  y2r_pkg::term_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output y2r_pkg::rgb_pair_t out_data
);

    y2r_pkg::sum_val_t r0;
    y2r_pkg::sum_val_t g0;
    y2r_pkg::sum_val_t b0;
    y2r_pkg::sum_val_t r1;
    y2r_pkg::sum_val_t g1;
    y2r_pkg::sum_val_t b1;
    y2r_pkg::sum_val_t g_chroma;
    y2r_pkg::rgb_pair_t rgb_next;
    y2r_pkg::rgb_pair_t rgb_reg;
    logic valid_reg;

    function automatic logic [7:0] clamp8(input y2r_pkg::sum_val_t v);
        if (v[y2r_pkg::SUM_W-1])
        begin
            return 8'd0;
        end
        else if (v[y2r_pkg::SUM_W-2:8] != '0)
        begin
            return y2r_pkg::PIXEL_MAX;
        end
        return v[7:0];
    endfunction

    // Both pixels share the chroma terms; only the luma term differs.
    assign g_chroma = y2r_pkg::ext_term(in_data.gv) + y2r_pkg::ext_term(in_data.gu);
    assign r0 = y2r_pkg::ext_term(in_data.y0) + y2r_pkg::ext_term(in_data.rv);
    assign g0 = y2r_pkg::ext_term(in_data.y0) + g_chroma;
    assign b0 = y2r_pkg::ext_term(in_data.y0) + y2r_pkg::ext_term(in_data.bu);
    assign r1 = y2r_pkg::ext_term(in_data.y1) + y2r_pkg::ext_term(in_data.rv);
    assign g1 = y2r_pkg::ext_term(in_data.y1) + g_chroma;
    assign b1 = y2r_pkg::ext_term(in_data.y1) + y2r_pkg::ext_term(in_data.bu);

    // Clamp every channel to the byte range.
    always_comb
    begin
        rgb_next.red_first    = clamp8(r0);
        rgb_next.green_first  = clamp8(g0);
        rgb_next.blue_first   = clamp8(b0);
        rgb_next.red_second   = clamp8(r1);
        rgb_next.green_second = clamp8(g1);
        rgb_next.blue_second  = clamp8(b1);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

endmodule

@@ tb/yuyv_to_rgb888_converter_tb.sv @@
module yuyv_to_rgb888_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // BT.601 coefficients held as thousandths, with the component offsets.
    localparam int GAIN_Y_MILLI  = 1164;
    localparam int GAIN_RV_MILLI = 1596;
    localparam int GAIN_GV_MILLI = -813;
    localparam int GAIN_BU_MILLI = 2018;
    localparam int GAIN_GU_MILLI = -391;
    localparam int LUMA_BLACK    = 16;
    localparam int CHROMA_ZERO   = 128;
    localparam int CHANNEL_TOP   = 255;

    localparam int RANDOM_PIXELS = 630;
    localparam int DRAIN_CYCLES  = 8;

    // One macropixel as packed on tdata, luma_first in the lowest byte.
    typedef struct packed {
        logic [7:0] chroma_red;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] luma_first;
    } macropixel_t;

    // Two RGB888 pixels as packed on tdata, red_first in the lowest byte.
    typedef struct packed {
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // A directed row; where known_rgb is set, the pair is typed in directly.
    typedef struct packed {
        logic [7:0]  luma_first;
        logic [7:0]  chroma_blue;
        logic [7:0]  luma_second;
        logic [7:0]  chroma_red;
        logic        known_rgb;
        logic [47:0] rgb_pair;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;

    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // Gray at black, white and above white; below black clamps to zero.
        '{8'd16,  8'd128, 8'd16,  8'd128, 1'b1, 48'h000000000000},
        '{8'd235, 8'd128, 8'd235, 8'd128, 1'b1, 48'hFEFEFEFEFEFE},
        '{8'd255, 8'd128, 8'd255, 8'd128, 1'b1, 48'hFFFFFFFFFFFF},
        '{8'd0,   8'd128, 8'd0,   8'd128, 1'b1, 48'h000000000000},
        // Field extremes together.
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 48'h0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 48'h0},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 48'h0},
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 48'h0},
        // Chroma on one axis, then on both, so the green weights on U and V show apart.
        '{8'd128, 8'd0,   8'd128, 8'd128, 1'b0, 48'h0},
        '{8'd128, 8'd255, 8'd128, 8'd128, 1'b0, 48'h0},
        '{8'd128, 8'd128, 8'd128, 8'd0,   1'b0, 48'h0},
        '{8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 48'h0},
        '{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 48'h0},
        '{8'd128, 8'd255, 8'd128, 8'd0,   1'b0, 48'h0},
        // Pixels of one pair far apart in luma.
        '{8'd16,  8'd0,   8'd235, 8'd255, 1'b0, 48'h0},
        '{8'd235, 8'd255, 8'd16,  8'd0,   1'b0, 48'h0},
        // Alternating and walking bit patterns.
        '{8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, 48'h0},
        '{8'hAA,  8'h55,  8'hAA,  8'h55,  1'b0, 48'h0},
        '{8'h01,  8'h80,  8'hFE,  8'h7F,  1'b0, 48'h0},
        '{8'h80,  8'h01,  8'h7F,  8'hFE,  1'b0, 48'h0},
        // Ordinary saturated colors.
        '{8'd81,  8'd90,  8'd145, 8'd240, 1'b0, 48'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    pixel_pair_t pending_pairs[$];
    int          mismatch_count = 0;
    int          pairs_checked = 0;
    int          pixels_sent = 0;
    int          send_burst_left = 0;
    int          take_burst_left = 0;

    yuyv_to_rgb888_converter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Coefficient times offset component, truncated toward zero.
    function automatic int scaled_component(input int gain_milli, input int offset_value);
        return (gain_milli * offset_value) / 1000;
    endfunction

    function automatic logic [7:0] clamp_channel(input int sum);
        if (sum < 0)
        begin
            return 8'd0;
        end
        if (sum > CHANNEL_TOP)
        begin
            return 8'd255;
        end
        return sum[7:0];
    endfunction

    function automatic rgb_t convert_pixel(input logic [7:0] luma, input int u_off,
                                           input int v_off);
        int   luma_term;
        rgb_t px;
        luma_term = scaled_component(GAIN_Y_MILLI, int'(luma) - LUMA_BLACK);
        px.red    = clamp_channel(luma_term + scaled_component(GAIN_RV_MILLI, v_off));
        px.green  = clamp_channel(luma_term + scaled_component(GAIN_GV_MILLI, v_off)
                                  + scaled_component(GAIN_GU_MILLI, u_off));
        px.blue   = clamp_channel(luma_term + scaled_component(GAIN_BU_MILLI, u_off));
        return px;
    endfunction

    function automatic pixel_pair_t convert_macropixel(input macropixel_t mp);
        int          u_off;
        int          v_off;
        rgb_t        first_px;
        rgb_t        second_px;
        pixel_pair_t pair;
        u_off     = int'(mp.chroma_blue) - CHROMA_ZERO;
        v_off     = int'(mp.chroma_red) - CHROMA_ZERO;
        first_px  = convert_pixel(mp.luma_first, u_off, v_off);
        second_px = convert_pixel(mp.luma_second, u_off, v_off);
        pair.red_first    = first_px.red;
        pair.green_first  = first_px.green;
        pair.blue_first   = first_px.blue;
        pair.red_second   = second_px.red;
        pair.green_second = second_px.green;
        pair.blue_second  = second_px.blue;
        return pair;
    endfunction

    // Byte values leaning toward the clamp edges and the offset points.
    function automatic logic [7:0] pick_component();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd16;
            3:       return 8'd128;
            4:       return 8'd235;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Idle gap for one side: usually drawn at random, with occasional gap-free runs.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Queue the expected pair, then hold the transfer until it is taken.
    task automatic send_macropixel(input macropixel_t mp, input pixel_pair_t pair);
        int gap;
        gap = draw_gap(send_burst_left);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        pending_pairs.push_back(pair);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mp;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    task automatic compare_channel(input string field, input logic [7:0] expected,
                                   input logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            mismatch_count++;
        end
    endtask

    task automatic check_pair(input pixel_pair_t actual);
        pixel_pair_t expected;
        if (pending_pairs.size() == 0)
        begin
            $error("unexpected output transfer 0x%012h", actual);
            mismatch_count++;
            return;
        end
        expected = pending_pairs.pop_front();
        compare_channel("red_first", expected.red_first, actual.red_first);
        compare_channel("green_first", expected.green_first, actual.green_first);
        compare_channel("blue_first", expected.blue_first, actual.blue_first);
        compare_channel("red_second", expected.red_second, actual.red_second);
        compare_channel("green_second", expected.green_second, actual.green_second);
        compare_channel("blue_second", expected.blue_second, actual.blue_second);
        pairs_checked++;
    endtask

    // Output transfers are checked as they happen.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_pair(m_axis_tdata);
        end
    end

    // Output side: stall a random number of cycles, then accept one transfer.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(take_burst_left);
            repeat (stall)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
            begin
                @(posedge clk);
            end
        end
    end

    // Input side: directed table first, then random macropixels.
    initial
    begin
        macropixel_t mp;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            mp.luma_first  = directed_rows[row].luma_first;
            mp.chroma_blue = directed_rows[row].chroma_blue;
            mp.luma_second = directed_rows[row].luma_second;
            mp.chroma_red  = directed_rows[row].chroma_red;
            if (directed_rows[row].known_rgb)
            begin
                send_macropixel(mp, directed_rows[row].rgb_pair);
            end
            else
            begin
                send_macropixel(mp, convert_macropixel(mp));
            end
        end

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            mp.luma_first  = pick_component();
            mp.chroma_blue = pick_component();
            mp.luma_second = pick_component();
            mp.chroma_red  = pick_component();
            send_macropixel(mp, convert_macropixel(mp));
        end
        s_axis_tvalid <= 1'b0;

        // Drain the pipeline, then wait out DRAIN_CYCLES for stray output.
        while (pending_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d macropixels (%0d directed, the rest random) under random",
                 pixels_sent, DIRECTED_ROWS);
        $display("input gaps and output stalls; %0d pixel pairs checked.", pairs_checked);
        if (mismatch_count == 0)
        begin
            $display("yuyv_to_rgb888_converter: match");
        end
        else
        begin
            $display("yuyv_to_rgb888_converter: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d pixel pairs outstanding.", pending_pairs.size());
        $display("yuyv_to_rgb888_converter: mismatch");
        $finish;
    end

endmodule
